// ===== hw/rtl/zsbf_pkg.sv =====
// Shared constants for the zlib stored-block framer: stream bytes, Adler-32
// modulus and the slot codes of one output burst. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package zsbf_pkg;

	localparam int LENGTH_BITS = 24;

	localparam logic [7:0]  ZLIB_CMF  = 8'h78;
	localparam logic [7:0]  ZLIB_FLG  = 8'h01;
	localparam logic [15:0] BLOCK_MAX = 16'hFFFF;
	localparam logic [16:0] ADLER_MOD = 17'd65521;

	// Slot codes of one burst: header, block header, data, trailer
	localparam logic [3:0] SLOT_HDR0 = 4'd0;
	localparam logic [3:0] SLOT_HDR1 = 4'd1;
	localparam logic [3:0] SLOT_BTYP = 4'd2;
	localparam logic [3:0] SLOT_LEN0 = 4'd3;
	localparam logic [3:0] SLOT_LEN1 = 4'd4;
	localparam logic [3:0] SLOT_NLN0 = 4'd5;
	localparam logic [3:0] SLOT_NLN1 = 4'd6;
	localparam logic [3:0] SLOT_DATA = 4'd7;
	localparam logic [3:0] SLOT_TRL0 = 4'd8;
	localparam logic [3:0] SLOT_TRL1 = 4'd9;
	localparam logic [3:0] SLOT_TRL2 = 4'd10;
	localparam logic [3:0] SLOT_TRL3 = 4'd11;

	// One conditional subtract; the sum stays below twice the modulus
	function automatic logic [15:0] adler_fold(input logic [16:0] sum);
		logic [16:0] red;
		red = (sum >= ADLER_MOD) ? (sum - ADLER_MOD) : sum;
		return red[15:0];
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/zlib_stored_block_framer.sv =====
// Top level of the zlib stored-block framer: input register, framing and
// Adler-32 update, burst register and byte sequencer. Depends on zsbf_pkg.
`timescale 1ns / 1ps
`default_nettype none

// channel  direction  handshake               word
// in       sink       in_valid / in_ready     data_byte, message_length
// out      source     out_valid / out_ready   out_byte, run_last, stream_end
//
// Each input word yields 0 to 12 output words, one per cycle while out_ready is high; a zero-length
// opening word yields none and leaves a bubble in the output.
// A stream of payload bytes inside a block runs at one word per cycle while out_ready is high.
// The input register takes a new word in the cycle the burst register drains
// its last byte, so bursts follow each other with no gap.
// arst_n clears all control state and the Adler sums to their start values.
// out_ready low holds the current burst; in_ready drops once the input
// register is also full.
module zlib_stored_block_framer
	import zsbf_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [7:0]             data_byte,
	input  wire logic [LENGTH_BITS-1:0] message_length,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic [7:0]                  out_byte,
	output logic                        run_last,
	output logic                        stream_end
);

	// input register
	logic                   v_s1;
	logic [7:0]             data_s1;
	logic [LENGTH_BITS-1:0] len_s1;

	// framing state
	logic                   open_q;
	logic [LENGTH_BITS-1:0] msg_left_q;
	logic [15:0]            blk_left_q;
	logic [15:0]            adl_lo_q;
	logic [15:0]            adl_hi_q;

	// burst register
	logic        v_s2;
	logic        hdr_s2;
	logic        blk_s2;
	logic        fin_s2;
	logic        trl_s2;
	logic [15:0] chunk_s2;
	logic [7:0]  data_s2;
	logic [15:0] adl_lo_s2;
	logic [15:0] adl_hi_s2;
	logic [3:0]  pos_q;

	logic                   adv;
	logic                   out_take;
	logic                   last_pos;
	logic                   skip;
	logic                   need_blk;
	logic                   fin;
	logic                   trl;
	logic [LENGTH_BITS-1:0] len_eff;
	logic [LENGTH_BITS-1:0] msg_after;
	logic [15:0]            blk_cur;
	logic [15:0]            chunk;
	logic [15:0]            blk_after;
	logic [15:0]            lo_base;
	logic [15:0]            hi_base;
	logic [15:0]            lo_new;
	logic [15:0]            hi_new;
	logic [15:0]            nchunk;
	logic [3:0]             pos_start;
	logic [3:0]             pos_next;

	assign out_valid = v_s2;
	assign out_take  = v_s2 && out_ready;
	assign last_pos  = (pos_q == SLOT_TRL3) || ((pos_q == SLOT_DATA) && !trl_s2);
	assign adv       = v_s1 && (!v_s2 || (out_take && last_pos));
	assign in_ready  = !v_s1 || adv;

	// framing decisions for the word in the input register
	always_comb begin
		len_eff   = open_q ? msg_left_q : len_s1;
		skip      = !open_q && (len_s1 == '0);
		blk_cur   = open_q ? blk_left_q : 16'd0;
		need_blk  = (blk_cur == 16'd0);
		fin       = (len_eff <= LENGTH_BITS'(BLOCK_MAX));
		chunk     = fin ? len_eff[15:0] : BLOCK_MAX;
		blk_after = (need_blk ? chunk : blk_cur) - 16'd1;
		msg_after = len_eff - LENGTH_BITS'(1);
		trl       = (msg_after == '0);
		lo_base   = open_q ? adl_lo_q : 16'd1;
		hi_base   = open_q ? adl_hi_q : 16'd0;
		lo_new    = adler_fold({1'b0, lo_base} + {9'd0, data_s1});
		hi_new    = adler_fold({1'b0, hi_base} + {1'b0, lo_new});
		pos_start = !open_q ? SLOT_HDR0 : (need_blk ? SLOT_BTYP : SLOT_DATA);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= data_byte;
			len_s1  <= message_length;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q     <= 1'b0;
			msg_left_q <= '0;
			blk_left_q <= 16'd0;
			adl_lo_q   <= 16'd1;
			adl_hi_q   <= 16'd0;
		end else if (adv && !skip) begin
			open_q     <= !trl;
			msg_left_q <= msg_after;
			blk_left_q <= trl ? 16'd0 : blk_after;
			adl_lo_q   <= trl ? 16'd1 : lo_new;
			adl_hi_q   <= trl ? 16'd0 : hi_new;
		end
	end

	// advance through the slots of the current burst
	always_comb begin
		unique case (pos_q)
			SLOT_HDR1: pos_next = blk_s2 ? SLOT_BTYP : SLOT_DATA;
			SLOT_NLN1: pos_next = SLOT_DATA;
			SLOT_DATA: pos_next = SLOT_TRL0;
			default:   pos_next = pos_q + 4'd1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2  <= 1'b0;
			pos_q <= SLOT_HDR0;
		end else if (adv) begin
			v_s2  <= !skip;
			pos_q <= pos_start;
		end else if (out_take) begin
			if (last_pos) begin
				v_s2 <= 1'b0;
			end else begin
				pos_q <= pos_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hdr_s2    <= !open_q;
			blk_s2    <= need_blk;
			fin_s2    <= fin;
			trl_s2    <= trl;
			chunk_s2  <= chunk;
			data_s2   <= data_s1;
			adl_lo_s2 <= lo_new;
			adl_hi_s2 <= hi_new;
		end
	end

	assign nchunk = ~chunk_s2;

	always_comb begin
		unique case (pos_q)
			SLOT_HDR0: out_byte = ZLIB_CMF;
			SLOT_HDR1: out_byte = ZLIB_FLG;
			SLOT_BTYP: out_byte = {7'd0, fin_s2};
			SLOT_LEN0: out_byte = chunk_s2[7:0];
			SLOT_LEN1: out_byte = chunk_s2[15:8];
			SLOT_NLN0: out_byte = nchunk[7:0];
			SLOT_NLN1: out_byte = nchunk[15:8];
			SLOT_DATA: out_byte = data_s2;
			SLOT_TRL0: out_byte = adl_hi_s2[15:8];
			SLOT_TRL1: out_byte = adl_hi_s2[7:0];
			SLOT_TRL2: out_byte = adl_lo_s2[15:8];
			SLOT_TRL3: out_byte = adl_lo_s2[7:0];
			default:   out_byte = 8'd0;
		endcase
	end

	assign run_last   = last_pos;
	assign stream_end = (pos_q == SLOT_TRL3);

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stream_end |-> run_last)
		else $error("stream end not on the last word of its burst");

	a_open_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		open_q |-> (msg_left_q != '0))
		else $error("open message with no bytes left");

	a_block_in_message: assert property (@(posedge clk) disable iff (!arst_n)
		open_q |-> (LENGTH_BITS'(blk_left_q) <= msg_left_q))
		else $error("block remainder exceeds message remainder");

	a_adler_range: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, adl_lo_q} < ADLER_MOD) && ({1'b0, adl_hi_q} < ADLER_MOD))
		else $error("Adler sum out of range");

	a_hdr_opens_block: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && hdr_s2 |-> blk_s2)
		else $error("stream header without block header");

endmodule

`default_nettype wire
